[rtl/lph_pkg.sv]
package lph_pkg;

  localparam int SLOT_COUNT_DEF = 65536;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int TSIZE_W        = 17;
  localparam int STATUS_W       = 3;
  localparam int SIDX_W         = 16;
  localparam int DCNT_W         = 32;
  localparam int ENTRY_W        = 1 + KEY_W + VAL_W;
  localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(65536);

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_NEGATIVE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK
  } state_t;

  localparam logic KIND_INSERT = 1'b0;

endpackage

[rtl/lph_ram.sv]
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/lph_rem.sv]
module lph_rem
  import lph_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [KEY_W-2:0]                dividend,
  input  logic [$clog2(SLOT_COUNT+1)-1:0] divisor,
  output logic                            done,
  output logic [$clog2(SLOT_COUNT)-1:0]   remainder
);

  localparam int SZ_W  = $clog2(SLOT_COUNT + 1);
  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int DVD_W = KEY_W - 1;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic             active;
  logic [CNT_W-1:0] step;
  logic [DVD_W-1:0] dvd;
  logic [SZ_W-1:0]  dvs;
  logic [SZ_W-1:0]  rem;
  logic [SZ_W:0]    trial;
  logic             ge;
  logic [SZ_W-1:0]  rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial    = {rem, dvd[DVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? SZ_W'(trial - {1'b0, dvs}) : trial[SZ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (active) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // Remainder is below the divisor, which never exceeds the slot count.
  assign remainder = rem[IDX_W-1:0];

endmodule

[rtl/linear_probe_hash_table.sv]
// Channel   Handshake            Payload                                     Direction
// --------  -------------------  ------------------------------------------  ---------
// request   start & !busy        kind, key, value                            in
// result    done (one cycle)     status, found_value, slot_index,            out
//                                duplicate_count
// config    cfg_we               cfg_data (slot_limit)                       in
//
// Flow: a non-negative key goes from accept to result through the bit-serial remainder
// unit, which computes the home slot, and then through the probing of slots in turn (one
// single-port slot RAM read per cycle). A negative key returns its result the cycle
// after accept.
// Reset: busy stays high for SLOT_COUNT cycles while a clearing pass zeroes every slot.
// The receiver cannot stall: each result is shown for exactly one cycle on done.
// slot_limit may be written at any time; it is sampled when an item is accepted.
module linear_probe_hash_table
  import lph_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic signed [KEY_W-1:0]    key,
  input  logic signed [VAL_W-1:0]    value,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VAL_W-1:0]    found_value,
  output logic [SIDX_W-1:0]          slot_index,
  output logic [DCNT_W-1:0]          duplicate_count,
  input  logic                       cfg_we,
  input  logic [TSIZE_W-1:0]         cfg_data
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int SZ_W  = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  // Control state
  state_t              state, state_next;
  logic [IDX_W-1:0]    clr_addr, clr_addr_next;
  logic                done_next;
  logic [DCNT_W-1:0]   dup, dup_next;
  logic [TSIZE_W-1:0]  slot_limit;

  // Per-item payload
  logic                kind_q, kind_q_next;
  logic [KEY_W-1:0]    key_q, key_q_next;
  logic [VAL_W-1:0]    value_q, value_q_next;
  logic [IDX_W-1:0]    size_m1, size_m1_next;
  logic [IDX_W-1:0]    slot, slot_next;
  logic [IDX_W-1:0]    n, n_next;
  status_t             status_q, status_q_next;
  logic [VAL_W-1:0]    fval, fval_next;
  logic [SIDX_W-1:0]   sidx, sidx_next;

  // Slot RAM and remainder unit hookup
  logic                ram_we;
  logic [IDX_W-1:0]    ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                rem_load;
  logic                rem_done;
  logic [IDX_W-1:0]    rem_out;
  logic [SZ_W-1:0]     size_use;
  logic [IDX_W-1:0]    slot_inc;
  logic                entry_valid;
  logic [KEY_W-1:0]    entry_key;
  logic [VAL_W-1:0]    entry_val;

  // Clamp the configured size: zero acts as one, oversize acts as the slot count.
  always_comb begin
    if (slot_limit == '0) begin
      size_use = SZ_W'(1);
    end else if (32'(slot_limit) > 32'(SLOT_COUNT)) begin
      size_use = SZ_W'(SLOT_COUNT);
    end else begin
      size_use = SZ_W'(slot_limit);
    end
  end

  assign entry_valid = ram_rdata[ENTRY_W-1];
  assign entry_key   = ram_rdata[VAL_W +: KEY_W];
  assign entry_val   = ram_rdata[VAL_W-1:0];

  // Advance one slot, wrapping from the last slot in use back to zero.
  assign slot_inc = (slot == size_m1) ? '0 : slot + 1'b1;

  lph_rem #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .load      (rem_load),
    .dividend  (key[KEY_W-2:0]),
    .divisor   (size_use),
    .done      (rem_done),
    .remainder (rem_out)
  );

  lph_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    done_next     = 1'b0;
    dup_next      = dup;
    kind_q_next   = kind_q;
    key_q_next    = key_q;
    value_q_next  = value_q;
    size_m1_next  = size_m1;
    slot_next     = slot;
    n_next        = n;
    status_q_next = status_q;
    fval_next     = fval;
    sidx_next     = sidx;
    ram_we        = 1'b0;
    ram_addr      = slot;
    ram_wdata     = {1'b1, key_q, value_q};
    rem_load      = 1'b0;

    unique case (state)
      S_CLEAR: begin
        // Sweep every slot to empty, one per cycle.
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          kind_q_next  = kind;
          key_q_next   = key;
          value_q_next = value;
          size_m1_next = IDX_W'(size_use - 1'b1);
          if (key[KEY_W-1]) begin
            // Reject negative keys straight away.
            status_q_next = ST_NEGATIVE;
            fval_next     = '0;
            sidx_next     = '0;
            done_next     = 1'b1;
          end else begin
            rem_load   = 1'b1;
            state_next = S_DIV;
          end
        end
      end

      S_DIV: begin
        // Issue the read of the home slot as soon as the remainder lands.
        if (rem_done) begin
          ram_addr   = rem_out;
          slot_next  = rem_out;
          n_next     = '0;
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        fval_next = '0;
        sidx_next = '0;
        if (!entry_valid) begin
          if (kind_q == KIND_INSERT) begin
            ram_we        = 1'b1;
            status_q_next = ST_INSERTED;
            sidx_next     = SIDX_W'(slot);
          end else begin
            status_q_next = ST_NOT_FOUND;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (entry_key == key_q) begin
          if (kind_q == KIND_INSERT) begin
            status_q_next = ST_DUPLICATE;
            if (dup != '1) begin
              dup_next = dup + 1'b1;
            end
          end else begin
            status_q_next = ST_FOUND;
            fval_next     = entry_val;
            sidx_next     = SIDX_W'(slot);
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (n == size_m1) begin
          // Full circle without a stop.
          status_q_next = (kind_q == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
          done_next     = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ram_addr  = slot_inc;
          slot_next = slot_inc;
          n_next    = n + 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      done       <= 1'b0;
      dup        <= '0;
      slot_limit <= TSIZE_RESET;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
      dup      <= dup_next;
      if (cfg_we) begin
        slot_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_q   <= kind_q_next;
    key_q    <= key_q_next;
    value_q  <= value_q_next;
    size_m1  <= size_m1_next;
    slot     <= slot_next;
    n        <= n_next;
    status_q <= status_q_next;
    fval     <= fval_next;
    sidx     <= sidx_next;
  end

  assign busy            = (state != S_IDLE);
  assign status          = status_q;
  assign found_value     = fval;
  assign slot_index      = sidx;
  assign duplicate_count = dup;

`ifndef SYNTHESIS
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (slot <= size_m1 && n <= size_m1))
    else $error("probe slot or count beyond table size");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && rem_done) |-> (rem_out <= size_m1))
    else $error("home slot beyond table size");

  a_fval_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status_q != ST_FOUND) |-> (fval == '0))
    else $error("found_value nonzero without a hit");

  a_dup_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |=> (dup == $past(dup) || dup == $past(dup) + 1'b1))
    else $error("duplicate count jumped");

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_CHECK) |-> (kind_q == KIND_INSERT && !entry_valid))
    else $error("slot write outside an insert into an empty slot");
`endif

endmodule

[tb/sv/tb.sv]
module tb;
  import lph_pkg::*;

  localparam logic KIND_SEARCH = ~KIND_INSERT;
  localparam int   PHASE_COUNT = 12;
  localparam int   PHASE_ITEMS = 104;
  localparam int   DRAIN_CYCLES = 40;

  // One result item as the block reports it.
  typedef struct packed {
    status_t             st;
    logic [VAL_W-1:0]    fv;
    logic [SIDX_W-1:0]   sidx;
    logic [DCNT_W-1:0]   dups;
  } hash_result_t;

  // One row of the directed stimulus: an optional slot limit write before the
  // item, the item itself, and a hand-written result where one is given.
  typedef struct {
    bit                  do_cfg;
    logic [TSIZE_W-1:0]  cfg;
    logic                k;
    logic [KEY_W-1:0]    ky;
    logic [VAL_W-1:0]    vl;
    bit                  typed;
    hash_result_t        want;
  } dir_row_t;

  localparam hash_result_t NO_RES = '{ST_INSERTED, 32'h0, 16'h0, 32'h0};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       kind = KIND_INSERT;
  logic signed [KEY_W-1:0]    key = '0;
  logic signed [VAL_W-1:0]    value = '0;
  logic                       done;
  logic [STATUS_W-1:0]        status;
  logic signed [VAL_W-1:0]    found_value;
  logic [SIDX_W-1:0]          slot_index;
  logic [DCNT_W-1:0]          duplicate_count;
  logic                       cfg_we = 1'b0;
  logic [TSIZE_W-1:0]         cfg_data = '0;

  // Shadow copy of the table, the size register and the duplicate counter.
  bit                  tbl_valid [SLOT_COUNT_DEF];
  logic [KEY_W-1:0]    tbl_key   [SLOT_COUNT_DEF];
  logic [VAL_W-1:0]    tbl_value [SLOT_COUNT_DEF];
  logic [TSIZE_W-1:0]  tsize_model = TSIZE_RESET;
  logic [DCNT_W-1:0]   dup_total = '0;

  hash_result_t        pending_results [$];
  logic [KEY_W-1:0]    stored_keys [$];
  int                  mismatch_count = 0;
  dir_row_t            dir_rows [19];

  linear_probe_hash_table u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .key             (key),
    .value           (value),
    .done            (done),
    .status          (status),
    .found_value     (found_value),
    .slot_index      (slot_index),
    .duplicate_count (duplicate_count),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs or never drops busy.
  initial begin
    #30_000_000;
    $display("tb failed");
    $finish;
  end

  // Clamp the size register the way the block does: zero acts as one slot,
  // anything above the slot count acts as the full table.
  function automatic int unsigned active_slots(input logic [TSIZE_W-1:0] sz);
    if (sz == 0) return 1;
    if (sz > SLOT_COUNT_DEF) return SLOT_COUNT_DEF;
    return sz;
  endfunction

  // Walk the shadow table for one item, update it, and return the result.
  function automatic hash_result_t probe_table(input logic k, input logic [KEY_W-1:0] ky,
                                               input logic [VAL_W-1:0] vl);
    hash_result_t r;
    int unsigned  sz;
    int unsigned  slot;
    int unsigned  n;
    bit           hit;
    r = NO_RES;
    r.st = ST_NEGATIVE;
    if (!ky[KEY_W-1]) begin
      sz = active_slots(tsize_model);
      slot = ky % sz;
      hit = 1'b0;
      if (k == KIND_INSERT) r.st = ST_FULL;
      else r.st = ST_NOT_FOUND;
      for (n = 0; n < sz && !hit; n++) begin
        if (!tbl_valid[slot]) begin
          // Empty slot ends the walk: claim it on insert, give up on search.
          if (k == KIND_INSERT) begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = ky;
            tbl_value[slot] = vl;
            r.st   = ST_INSERTED;
            r.sidx = slot[SIDX_W-1:0];
          end else begin
            r.st = ST_NOT_FOUND;
          end
          hit = 1'b1;
        end else if (tbl_key[slot] == ky) begin
          // Key already present: refuse the insert and count it, or report it.
          if (k == KIND_INSERT) begin
            if (dup_total != '1) dup_total++;
            r.st = ST_DUPLICATE;
          end else begin
            r.st   = ST_FOUND;
            r.fv   = tbl_value[slot];
            r.sidx = slot[SIDX_W-1:0];
          end
          hit = 1'b1;
        end else begin
          slot = (slot + 1 >= sz) ? 0 : slot + 1;
        end
      end
    end
    r.dups = dup_total;
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Present one item and hold it until the block takes it. On the accepting
  // edge predict the result and queue it; a hand-written result, where given,
  // replaces the prediction in the queue while the shadow state still advances.
  task automatic send_item(input logic k, input logic [KEY_W-1:0] ky,
                           input logic [VAL_W-1:0] vl, input int gap,
                           input bit typed, input hash_result_t want);
    hash_result_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    key   <= ky;
    value <= vl;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = probe_table(k, ky, vl);
    if (pred.st == ST_INSERTED) stored_keys.push_back(ky);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Stop sending and hold until every queued result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the slot limit with the block idle and mirror it in the shadow copy.
  task automatic write_size(input logic [TSIZE_W-1:0] sz);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    tsize_model = sz;
  endtask

  // Check each result against the oldest queued one, field by field.
  always @(posedge clk) begin : check_results
    hash_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d found_value %h slot_index %0d dups %0d",
                   status, found_value, slot_index, duplicate_count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st || found_value !== want.fv ||
            slot_index !== want.sidx || duplicate_count !== want.dups) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp status %0d fv %h slot %0d dups %0d, got %0d %h %0d %0d",
                     want.st, want.fv, want.sidx, want.dups,
                     status, found_value, slot_index, duplicate_count);
        end
      end
    end
  end

  initial begin : stimulus
    logic [TSIZE_W-1:0] phase_sizes [PHASE_COUNT];
    int unsigned        sz_eff;
    int unsigned        pool_hi;
    int                 sel;
    bit                 burst;
    logic               k;
    logic [KEY_W-1:0]   ky;

    // Directed rows: empty table at reset size, extremes of key and value,
    // wraparound from the last slot, size zero and over-range, full circles
    // on insert and search, entries hidden above a shrunk size, duplicates.
    dir_rows = '{
      '{0, 0, KIND_SEARCH, 32'h0000_0000, 32'h0000_0000, 1,
        '{ST_NOT_FOUND, 32'h0, 16'h0, 32'd0}},
      '{0, 0, KIND_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
        '{ST_INSERTED, 32'h0, 16'hFFFF, 32'd0}},
      '{0, 0, KIND_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, 1,
        '{ST_FOUND, 32'h7FFF_FFFF, 16'hFFFF, 32'd0}},
      '{0, 0, KIND_INSERT, 32'h7FFF_FFFF, 32'h0000_0001, 1,
        '{ST_DUPLICATE, 32'h0, 16'h0, 32'd1}},
      '{0, 0, KIND_SEARCH, 32'h8000_0000, 32'h0000_0000, 1,
        '{ST_NEGATIVE, 32'h0, 16'h0, 32'd1}},
      '{0, 0, KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
        '{ST_NEGATIVE, 32'h0, 16'h0, 32'd1}},
      '{0, 0, KIND_INSERT, 32'd131071, 32'h0000_0000, 0, NO_RES},
      '{0, 0, KIND_SEARCH, 32'd131071, 32'h0000_0000, 0, NO_RES},
      '{0, 0, KIND_INSERT, 32'h0000_0000, 32'h8000_0000, 0, NO_RES},
      '{1, 17'd0, KIND_INSERT, 32'd5, 32'h1234_5678, 0, NO_RES},
      '{0, 0, KIND_SEARCH, 32'd131071, 32'h0000_0000, 0, NO_RES},
      '{0, 0, KIND_SEARCH, 32'd9, 32'h0000_0000, 0, NO_RES},
      '{1, 17'h1FFFF, KIND_SEARCH, 32'h0000_0000, 32'h0000_0000, 0, NO_RES},
      '{1, 17'd3, KIND_INSERT, 32'd2, 32'hFFFF_FFFF, 0, NO_RES},
      '{0, 0, KIND_INSERT, 32'd5, 32'h0000_0000, 0, NO_RES},
      '{0, 0, KIND_SEARCH, 32'd8, 32'hFFFF_FFFF, 0, NO_RES},
      '{0, 0, KIND_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, 0, NO_RES},
      '{1, 17'd65536, KIND_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, 0, NO_RES},
      '{0, 0, KIND_INSERT, 32'd2, 32'h0000_0000, 0, NO_RES}
    };
    phase_sizes = '{17'd7, 17'd1, 17'd64, 17'h1FFFF, 17'd0, 17'd250,
                    17'd2, 17'd65535, 17'd16, 17'd65536, 17'd3, 17'd100};

    // Hold reset, then release it; the clearing pass shows up as busy.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) write_size(dir_rows[i].cfg);
      send_item(dir_rows[i].k, dir_rows[i].ky, dir_rows[i].vl, pick_gap(1'b0),
                dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, one table size each. Keys mostly come from a small pool
    // that collides on home slots, or repeat stored keys, so that probe chains,
    // duplicates, hits and full tables all come up; the rest is wide noise.
    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      sz_eff  = active_slots(phase_sizes[p]);
      pool_hi = (2 * sz_eff > 511) ? 511 : 2 * sz_eff;
      burst   = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        k   = 1'($urandom_range(0, 1));
        if (sel < 10)
          ky = {1'b1, 31'($urandom)};
        else if (sel < 60)
          ky = $urandom_range(0, pool_hi) + sz_eff * $urandom_range(0, 3);
        else if (sel < 80 && stored_keys.size() > 0)
          ky = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else
          ky = {1'b0, 31'($urandom)};
        send_item(k, ky, $urandom, pick_gap(burst), 1'b0, NO_RES);
      end
    end

    // Drain, let the block settle, then report.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
